// ===== hw/rtl/ctd_pkg.sv =====
package ctd_pkg;

  // default width of the chunk size counter
  localparam int unsigned SIZE_BITS_DEF = 32;

  // what a result word carries
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic        last;
  } res_t;

  // up to two results caused by one input word
  typedef struct packed {
    logic [1:0]  num;
    res_t        r0;
    res_t        r1;
  } pair_t;

endpackage

// ===== hw/rtl/ctd_step.sv =====
module ctd_step #(
  parameter int unsigned SIZE_BITS = ctd_pkg::SIZE_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    byte_i,
  input  logic          eob_i,
  output ctd_pkg::pair_t pair_o
);

  localparam logic [2:0] PH_LEAD   = 3'd0;
  localparam logic [2:0] PH_DIGITS = 3'd1;
  localparam logic [2:0] PH_TRAIL  = 3'd2;
  localparam logic [2:0] PH_EXT    = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;
  localparam logic [2:0] PH_CR     = 3'd5;
  localparam logic [2:0] PH_LF     = 3'd6;
  localparam logic [2:0] PH_TERM   = 3'd7;

  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_SEMI = 8'h3b;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_LINE = 2'd1;
  localparam logic [1:0] ACT_ERR  = 2'd2;

  localparam logic [SIZE_BITS-1:0] SZ_ONE = {{(SIZE_BITS-1){1'b0}}, 1'b1};

  logic [2:0]           ph_q, ph_d, ph_t;
  logic [SIZE_BITS-1:0] sz_q, sz_d;
  logic                 cr_q, cr_d;
  logic                 dg_q, dg_d;

  logic       is_hex, is_blank, skip;
  logic [3:0] hex_val;
  logic [1:0] act;
  logic       main_v, eob_err;
  ctd_pkg::res_t main_r, err_r;

  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (byte_i >= 8'h30 && byte_i <= 8'h39) begin
      hex_val = 4'(byte_i - 8'h30);
    end else if (byte_i >= 8'h61 && byte_i <= 8'h66) begin
      hex_val = 4'(byte_i - 8'h57);
    end else if (byte_i >= 8'h41 && byte_i <= 8'h46) begin
      hex_val = 4'(byte_i - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  // lone lf counts as a blank; cr is handled by the pending flag
  assign is_blank = (byte_i == CH_SP) || (byte_i == CH_TAB) || (byte_i == CH_LF);

  assign err_r = '{kind: ctd_pkg::KIND_ERR, data: 8'd0, last: 1'b1};

  always_comb begin
    ph_d   = ph_q;
    sz_d   = sz_q;
    cr_d   = cr_q;
    dg_d   = dg_q;
    ph_t   = ph_q;
    act    = ACT_NONE;
    skip   = 1'b0;
    main_v = 1'b0;
    main_r = err_r;

    unique case (ph_q)
      PH_LEAD, PH_DIGITS, PH_TRAIL, PH_EXT: begin
        if (cr_q) begin
          cr_d = 1'b0;
          if (byte_i == CH_LF) begin
            act  = ACT_LINE;
            skip = 1'b1;
          end else if (ph_q == PH_DIGITS) begin
            ph_t = PH_TRAIL;
          end
        end
        ph_d = ph_t;
        if (!skip) begin
          if (byte_i == CH_CR) begin
            cr_d = 1'b1;
          end else begin
            unique case (ph_t)
              PH_LEAD, PH_DIGITS: begin
                if (is_blank) begin
                  if (ph_t == PH_DIGITS) ph_d = PH_TRAIL;
                end else if (byte_i == CH_SEMI) begin
                  ph_d = PH_EXT;
                end else if (!is_hex) begin
                  act = ACT_ERR;
                end else if (sz_q[SIZE_BITS-1 -: 4] != 4'd0) begin
                  act = ACT_ERR;
                end else begin
                  ph_d = PH_DIGITS;
                  sz_d = {sz_q[SIZE_BITS-5:0], hex_val};
                  dg_d = 1'b1;
                end
              end
              PH_TRAIL: begin
                if (byte_i == CH_SEMI) begin
                  ph_d = PH_EXT;
                end else if (!is_blank) begin
                  act = ACT_ERR;
                end
              end
              default: begin
              end
            endcase
          end
        end
        if (act == ACT_LINE) begin
          if (!dg_q) begin
            act = ACT_ERR;
          end else if (sz_q == '0) begin
            ph_d   = PH_TERM;
            main_v = 1'b1;
            main_r = '{kind: ctd_pkg::KIND_DONE, data: 8'd0, last: 1'b1};
          end else begin
            ph_d = PH_DATA;
            dg_d = 1'b0;
          end
        end
        if (act == ACT_ERR) begin
          ph_d   = PH_TERM;
          main_v = 1'b1;
        end
      end
      PH_DATA: begin
        main_v = 1'b1;
        main_r = '{kind: ctd_pkg::KIND_DATA, data: byte_i, last: 1'b0};
        sz_d   = sz_q - SZ_ONE;
        if (sz_q == SZ_ONE) ph_d = PH_CR;
      end
      PH_CR: begin
        if (byte_i == CH_CR) begin
          ph_d = PH_LF;
        end else begin
          ph_d   = PH_TERM;
          main_v = 1'b1;
        end
      end
      PH_LF: begin
        if (byte_i == CH_LF) begin
          ph_d = PH_LEAD;
          sz_d = '0;
          dg_d = 1'b0;
          cr_d = 1'b0;
        end else begin
          ph_d   = PH_TERM;
          main_v = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // end of body flags an unfinished message and rearms for the next one
    eob_err = eob_i && (ph_d != PH_TERM);
    if (eob_i) begin
      ph_d = PH_LEAD;
      sz_d = '0;
      cr_d = 1'b0;
      dg_d = 1'b0;
    end
  end

  always_comb begin
    pair_o.r1 = err_r;
    if (main_v) begin
      pair_o.num = eob_err ? 2'd2 : 2'd1;
      pair_o.r0  = main_r;
    end else begin
      pair_o.num = eob_err ? 2'd1 : 2'd0;
      pair_o.r0  = err_r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_LEAD;
      sz_q <= '0;
      cr_q <= 1'b0;
      dg_q <= 1'b0;
    end else if (step_i) begin
      ph_q <= ph_d;
      sz_q <= sz_d;
      cr_q <= cr_d;
      dg_q <= dg_d;
    end
  end

  a_eob_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && eob_i |=> ph_q == PH_LEAD && sz_q == '0 && !cr_q && !dg_q)
    else $error("state not rearmed after end of body");

  a_data_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q == PH_DATA |-> sz_q != '0)
    else $error("payload phase with zero bytes left");

  a_pending_cr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cr_q |-> ph_q == PH_LEAD || ph_q == PH_DIGITS || ph_q == PH_TRAIL || ph_q == PH_EXT)
    else $error("cr pending outside a size line");

endmodule

// ===== hw/rtl/ctd_out_fifo.sv =====
module ctd_out_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ctd_pkg::pair_t pair_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           ready_i,
  output ctd_pkg::res_t  res_o
);

  ctd_pkg::pair_t ent_q [2];
  logic           wr_ptr_q, rd_ptr_q, sub_q;
  logic [1:0]     cnt_q;
  logic           fire, pop;
  ctd_pkg::pair_t head;

  assign head    = ent_q[rd_ptr_q];
  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign res_o   = sub_q ? head.r1 : head.r0;
  assign fire    = valid_o && ready_i;
  // the entry leaves once its last word is taken
  assign pop     = fire && (sub_q || head.num == 2'd1);

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wr_ptr_q] <= pair_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      sub_q    <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
        sub_q    <= 1'b0;
      end else if (fire) begin
        sub_q <= 1'b1;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full result queue");

  a_sub_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q |-> valid_o && head.num == 2'd2)
    else $error("second word selected on a single-word entry");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result queue count out of range");

endmodule

// ===== hw/rtl/chunked_transfer_decoder_core.sv =====
// chunked transfer decoder: strips http/1.1 chunk framing from a body stream
//
// slave side: one body byte per word on s_axis_tdata_i, s_axis_tlast_i set on the
//   final byte of a body. master side: one result word per transfer, tuser gives
//   its kind (payload byte, done, error), tdata the payload byte (zero otherwise),
//   tlast marks the done or error word that closes the body.
// a byte is taken into an input register, decoded from there once the result queue
//   has room, and its results written into a two-entry result queue, which offers
//   them one word at a time on the master side.
// throughput is one byte per clock while each byte yields at most one result and
//   the receiver keeps up; a payload byte that also ends the body early yields two
//   words, which the single result port then hands out one after the other.
// s_axis_tready_o depends only on registers: it drops while the input register is
//   loaded and the result queue is full, so a stalled receiver backs up into the
//   sender after at most three bytes that carry results; bytes of a size line
//   carry none and pass only while the queue has room; nothing is lost or dropped.
// reset clears the parser to the start of a size line and empties the queue;
//   every end of body does the same for the parser.
module chunked_transfer_decoder_core #(
  parameter int unsigned SIZE_BITS = ctd_pkg::SIZE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] data_byte
  input  logic       s_axis_tlast_i,  // end_of_body
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [7:0] out_byte
  output logic [1:0] m_axis_tuser_o,  // [1:0] kind
  output logic       m_axis_tlast_o   // final_res
);

  // input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_eob_q;

  logic           q_full, step, s_fire;
  ctd_pkg::pair_t pair;
  ctd_pkg::res_t  res;

  // the held word is decoded whenever the queue has room
  assign step            = in_vld_q && !q_full;
  assign s_axis_tready_o = !in_vld_q || !q_full;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_byte_q <= s_axis_tdata_i;
      in_eob_q  <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_fire) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  ctd_step #(
    .SIZE_BITS (SIZE_BITS)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .eob_i  (in_eob_q),
    .pair_o (pair)
  );

  ctd_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step && (pair.num != 2'd0)),
    .pair_i  (pair),
    .full_o  (q_full),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (res)
  );

  assign m_axis_tdata_o = res.data;
  assign m_axis_tuser_o = res.kind;
  assign m_axis_tlast_o = res.last;

endmodule
